### hw/rtl/ray_reflect_refract_unit_assert.svh
// ============================================================================
// Assertion macros for the ray reflect/refract unit
// Shared implication checks on the unit clock with a synchronous reset.
// ============================================================================
`ifndef RAY_REFLECT_REFRACT_UNIT_ASSERT_SVH
`define RAY_REFLECT_REFRACT_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Consequent must hold in the cycle after the antecedent.
`define RRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### hw/rtl/rrr_pkg.sv
// ============================================================================
// rrr_pkg
// Shared stage counts, constants, pipeline record and helpers.
// ============================================================================
package rrr_pkg;

   localparam int FRONT_STAGES = 10;
   localparam int SQRT_STAGES  = 12;
   localparam int BACK_STAGES  = 3;
   localparam int EPS_W        = 15;

   localparam logic [EPS_W-1:0] EPS_RESET = 15'd1;

   // One record travels down the whole pipeline; each stage fills its fields.
   typedef struct packed {
      logic              kind;
      logic [2:0][15:0]  d;
      logic [2:0][15:0]  nv;
      logic [15:0]       n;
      logic [2:0][31:0]  dp;
      logic [2:0][31:0]  dn;
      logic [32:0]       dot;
      logic [2:0][48:0]  rp;
      logic [18:0]       c;
      logic [35:0]       cc;
      logic [35:0]       nc;
      logic [2:0][15:0]  refl;
      logic [36:0]       sin2;
      logic [53:0]       sn;
      logic [41:0]       t;
      logic [58:0]       un;
      logic [47:0]       cos2r;
      logic              pass;
      logic [47:0]       rad;
      logic [26:0]       rem;
      logic [23:0]       root;
      logic [37:0]       k;
      logic [2:0][53:0]  kp;
      logic              tir;
   } pipe_type;

   function automatic logic [15:0] sat16(input logic signed [31:0] v);
      logic [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'h7fff;
      end else if (v < -32'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/rrr_front.sv
// ============================================================================
// rrr_front
// Dot product, reflection and the cos squared chain up to the refraction test.
// ============================================================================
module rrr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [rrr_pkg::EPS_W-1:0] eps,
   input  logic                      in_valid,
   input  rrr_pkg::pipe_type         in_data,
   output logic                      out_valid,
   output rrr_pkg::pipe_type         out_data
);
   import rrr_pkg::*;

   function automatic pipe_type front_step(input int s, input pipe_type x,
                                           input logic [EPS_W-1:0] e);
      pipe_type           y;
      logic signed [16:0] ns;
      logic signed [50:0] rsum;
      logic signed [34:0] negd;
      logic signed [47:0] u;
      logic signed [47:0] thr;
      y  = x;
      ns = $signed({1'b0, x.n});
      case (s)
         0: begin
            for (int i = 0; i < 3; i++) begin
               y.dp[i] = 32'($signed(x.d[i]) * $signed(x.nv[i]));
               y.dn[i] = 32'($signed(x.d[i]) * ns);
            end
         end
         1: begin
            y.dot = 33'($signed(x.dp[0])) + 33'($signed(x.dp[1]))
                  + 33'($signed(x.dp[2]));
         end
         2: begin
            for (int i = 0; i < 3; i++) begin
               y.rp[i] = 49'($signed(x.nv[i]) * $signed(x.dot));
            end
            negd = 35'sd8192 - 35'($signed(x.dot));
            y.c  = 19'(negd >>> 14);
         end
         3: begin
            for (int i = 0; i < 3; i++) begin
               rsum = (51'($signed(x.d[i])) <<< 28) - (51'($signed(x.rp[i])) <<< 1)
                    + 51'sd134217728;
               y.refl[i] = sat16(32'(rsum >>> 28));
            end
            y.cc = 36'($signed(x.c) * $signed(x.c));
            y.nc = 36'(ns * $signed(x.c));
         end
         4: begin
            y.sin2 = 37'd268435456 - {1'b0, x.cc};
         end
         5: begin
            y.sn = 54'($signed(x.sin2) * ns);
         end
         6: begin
            y.t = 42'(($signed(x.sn) + 54'sd2048) >>> 12);
         end
         7: begin
            y.un = 59'($signed(x.t) * ns);
         end
         8: begin
            u       = 48'(($signed(x.un) + 59'sd2048) >>> 12);
            y.cos2r = 48'(48'sd268435456 - u);
         end
         9: begin
            thr    = $signed({19'd0, e, 14'd0});
            y.pass = x.kind && ($signed(x.cos2r) > thr);
            y.rad  = y.pass ? x.cos2r : 48'd0;
            y.rem  = '0;
            y.root = '0;
         end
         default: begin
            y = x;
         end
      endcase
      return y;
   endfunction

   logic                     v_ff [FRONT_STAGES];
   pipe_type                 p_ff [FRONT_STAGES];
   pipe_type                 p_in [FRONT_STAGES];

   assign p_in[0] = front_step(0, in_data, eps);
   for (genvar s = 1; s < FRONT_STAGES; s++) begin : g_st
      assign p_in[s] = front_step(s, p_ff[s-1], eps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FRONT_STAGES; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < FRONT_STAGES; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < FRONT_STAGES; s++) p_ff[s] <= p_in[s];
      end
   end

   assign out_valid = v_ff[FRONT_STAGES-1];
   assign out_data  = p_ff[FRONT_STAGES-1];

endmodule

### hw/rtl/rrr_sqrt.sv
// ============================================================================
// rrr_sqrt
// Pipelined restoring integer square root, two result bits per stage.
// ============================================================================
module rrr_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rrr_pkg::pipe_type in_data,
   output logic              out_valid,
   output rrr_pkg::pipe_type out_data
);
   import rrr_pkg::*;

   function automatic pipe_type sqrt_step(input pipe_type x);
      pipe_type    y;
      logic [28:0] remx;
      logic [25:0] trial;
      y = x;
      for (int j = 0; j < 2; j++) begin
         remx  = {y.rem, y.rad[47:46]};
         trial = {y.root, 2'b01};
         if (remx >= {3'd0, trial}) begin
            y.rem  = 27'(remx - {3'd0, trial});
            y.root = {y.root[22:0], 1'b1};
         end else begin
            y.rem  = remx[26:0];
            y.root = {y.root[22:0], 1'b0};
         end
         y.rad = {y.rad[45:0], 2'b00};
      end
      return y;
   endfunction

   logic     v_ff [SQRT_STAGES];
   pipe_type p_ff [SQRT_STAGES];
   pipe_type p_in [SQRT_STAGES];

   assign p_in[0] = sqrt_step(in_data);
   for (genvar s = 1; s < SQRT_STAGES; s++) begin : g_st
      assign p_in[s] = sqrt_step(p_ff[s-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SQRT_STAGES; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < SQRT_STAGES; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_STAGES; s++) p_ff[s] <= p_in[s];
      end
   end

   assign out_valid = v_ff[SQRT_STAGES-1];
   assign out_data  = p_ff[SQRT_STAGES-1];

endmodule

### hw/rtl/rrr_back.sv
// ============================================================================
// rrr_back
// Refracted direction, fallback selection and the output register.
// ============================================================================
module rrr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  rrr_pkg::pipe_type in_data,
   output logic              out_valid,
   output rrr_pkg::pipe_type out_data
);
   import rrr_pkg::*;

   function automatic pipe_type back_step(input int s, input pipe_type x);
      pipe_type           y;
      logic signed [54:0] sum;
      y = x;
      case (s)
         0: begin
            y.k = 38'($signed(x.nc)) - {2'd0, x.root, 12'd0};
         end
         1: begin
            for (int i = 0; i < 3; i++) begin
               y.kp[i] = 54'($signed(x.nv[i]) * $signed(x.k));
            end
         end
         2: begin
            // A failed refraction test keeps the reflected vector.
            y.tir = x.kind && !x.pass;
            if (x.pass) begin
               for (int i = 0; i < 3; i++) begin
                  sum = (55'($signed(x.dn[i])) <<< 14) + 55'($signed(x.kp[i]))
                      + 55'sd33554432;
                  y.refl[i] = sat16(32'(sum >>> 26));
               end
            end
         end
         default: begin
            y = x;
         end
      endcase
      return y;
   endfunction

   logic     v_ff [BACK_STAGES];
   pipe_type p_ff [BACK_STAGES];
   pipe_type p_in [BACK_STAGES];

   assign p_in[0] = back_step(0, in_data);
   for (genvar s = 1; s < BACK_STAGES; s++) begin : g_st
      assign p_in[s] = back_step(s, p_ff[s-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < BACK_STAGES; s++) v_ff[s] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < BACK_STAGES; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < BACK_STAGES; s++) p_ff[s] <= p_in[s];
      end
   end

   assign out_valid = v_ff[BACK_STAGES-1];
   assign out_data  = p_ff[BACK_STAGES-1];

endmodule

### hw/rtl/ray_reflect_refract_unit.sv
// ============================================================================
// ray_reflect_refract_unit
// Reflects or refracts a Q2.14 direction at a surface, one item per cycle.
// ============================================================================
// Usage:
// An item enters on the req_ channel (valid/ready) with the kind, direction,
// normal and index ratio; the result leaves on the rsp_ channel with the
// saturated direction and the total reflection flag. Every item gives one
// result, in order. csr_write_enable writes the cos squared threshold; write
// it only while no item is in flight.
// From acceptance to rsp_valid an item passes ten stages of dot product and
// cos squared arithmetic, twelve square root stages at two root bits each,
// and three stages for the refracted vector and output register.
// Throughput is one item per cycle while the receiver does not stall,
// limited by the single pipeline advance. Reset empties the pipeline and
// sets the threshold to one. When the receiver stalls, the whole pipeline
// holds; one more item may be taken into a skid register, after which
// req_ready drops until the pipeline moves again.
`include "ray_reflect_refract_unit_assert.svh"

module ray_reflect_refract_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic signed [15:0]        req_dir_x,
   input  logic signed [15:0]        req_dir_y,
   input  logic signed [15:0]        req_dir_z,
   input  logic signed [15:0]        req_norm_x,
   input  logic signed [15:0]        req_norm_y,
   input  logic signed [15:0]        req_norm_z,
   input  logic [15:0]               req_index_ratio,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_out_x,
   output logic signed [15:0]        rsp_out_y,
   output logic signed [15:0]        rsp_out_z,
   output logic                      rsp_total_reflection,
   input  logic                      csr_write_enable,
   input  logic [rrr_pkg::EPS_W-1:0] csr_write_data
);
   import rrr_pkg::*;

   logic [EPS_W-1:0] epsilon_ff;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   pipe_type         skid_ff;
   pipe_type         req_pkt;
   pipe_type         head_data;
   logic             head_valid;
   logic             pipe_en;
   logic             req_fire;
   logic             f_valid;
   pipe_type         f_data;
   logic             s_valid;
   pipe_type         s_data;
   pipe_type         b_data;

   always_comb begin
      req_pkt       = '0;
      req_pkt.kind  = req_kind;
      req_pkt.d[0]  = req_dir_x;
      req_pkt.d[1]  = req_dir_y;
      req_pkt.d[2]  = req_dir_z;
      req_pkt.nv[0] = req_norm_x;
      req_pkt.nv[1] = req_norm_y;
      req_pkt.nv[2] = req_norm_z;
      req_pkt.n     = req_index_ratio;
   end

   assign pipe_en    = !rsp_valid || rsp_ready;
   assign req_ready  = !skid_valid_ff;
   assign req_fire   = req_valid && req_ready;
   assign head_valid = skid_valid_ff || req_fire;
   assign head_data  = skid_valid_ff ? skid_ff : req_pkt;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (pipe_en) begin
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         epsilon_ff    <= EPS_RESET;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (csr_write_enable) begin
            epsilon_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && req_fire) begin
         skid_ff <= req_pkt;
      end
   end

   rrr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .eps       (epsilon_ff),
      .in_valid  (head_valid),
      .in_data   (head_data),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   rrr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (s_valid),
      .out_data  (s_data)
   );

   rrr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s_valid),
      .in_data   (s_data),
      .out_valid (rsp_valid),
      .out_data  (b_data)
   );

   assign rsp_out_x            = b_data.refl[0];
   assign rsp_out_y            = b_data.refl[1];
   assign rsp_out_z            = b_data.refl[2];
   assign rsp_total_reflection = b_data.tir;

   `RRR_ASSERT_NEXT(a_skid_catches, clock, reset, req_fire && !pipe_en, skid_valid_ff)
   `RRR_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && pipe_en, !skid_valid_ff)
   `RRR_ASSERT_NEXT(a_csr_write, clock, reset, csr_write_enable, epsilon_ff == $past(csr_write_data))

endmodule

### bench/tb_ray_reflect_refract_unit.sv
// ----------------------------------------------------------------------------
// Testbench for ray_reflect_refract_unit
// Drives reflect and refract items with random bursts and receiver stalls,
// predicts each result with a fixed-point model and compares field by field.
// ----------------------------------------------------------------------------
module tb_ray_reflect_refract_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {KIND_REFLECT = 1'b0, KIND_REFRACT = 1'b1} kind_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic               tir;
   } dir_result_type;

   localparam longint ONE_Q28 = 64'sd1 << 28;
   localparam int PIPE_LATENCY = 25;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic signed [15:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [15:0] req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic [15:0] req_index_ratio = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_total_reflection;
   logic csr_write_enable = 1'b0;
   logic [rrr_pkg::EPS_W-1:0] csr_write_data = '0;

   logic [14:0] eps_model = rrr_pkg::EPS_RESET;
   dir_result_type pending_dirs[$];
   int error_count = 0;
   int results_seen = 0;
   int tir_seen = 0;
   int items_sent = 0;
   int hold_cycles = 0;
   bit stall_enable = 1'b0;

   ray_reflect_refract_unit i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint rnd_half_up(longint v, int s);
      longint x;
      x = v + (64'sd1 << (s - 1));
      return x >>> s;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint floor_sqrt(longint v);
      longint res, bitv;
      res = 0;
      bitv = 64'sd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic dir_result_type bend_ray(kind_type kind, longint d[3], longint nv[3],
                                                longint n);
      dir_result_type r;
      longint dot, c, sin2, t, u, cos2r, root, k;
      longint res[3];
      bit reflect;
      dot = d[0] * nv[0] + d[1] * nv[1] + d[2] * nv[2];
      reflect = (kind == KIND_REFLECT);
      r.tir = 1'b0;
      if (kind == KIND_REFRACT) begin
         c = rnd_half_up(-dot, 14);
         sin2 = ONE_Q28 - c * c;
         t = rnd_half_up(sin2 * n, 12);
         u = rnd_half_up(t * n, 12);
         cos2r = ONE_Q28 - u;
         if (cos2r > longint'(eps_model) * 16384) begin
            root = floor_sqrt(cos2r);
            k = n * c - root * 4096;
            for (int i = 0; i < 3; i++)
               res[i] = rnd_half_up(d[i] * n * 16384 + nv[i] * k, 26);
         end else begin
            r.tir = 1'b1;
            reflect = 1'b1;
         end
      end
      if (reflect) begin
         for (int i = 0; i < 3; i++)
            res[i] = rnd_half_up(d[i] * ONE_Q28 - 2 * nv[i] * dot, 28);
      end
      r.x = clamp16(res[0]);
      r.y = clamp16(res[1]);
      r.z = clamp16(res[2]);
      return r;
   endfunction

   task automatic send_ray(kind_type kind, logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                           logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                           logic [15:0] n);
      longint d[3], nv[3];
      d = '{longint'($signed(dx)), longint'($signed(dy)), longint'($signed(dz))};
      nv = '{longint'($signed(nx)), longint'($signed(ny)), longint'($signed(nz))};
      req_valid <= 1'b1;
      req_kind <= kind;
      req_dir_x <= dx;
      req_dir_y <= dy;
      req_dir_z <= dz;
      req_norm_x <= nx;
      req_norm_y <= ny;
      req_norm_z <= nz;
      req_index_ratio <= n;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_dirs.push_back(bend_ray(kind, d, nv, longint'(n)));
      items_sent++;
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_and_set_eps(logic [14:0] value);
      idle_gap(1);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      eps_model = value;
   endtask

   // A component that is often at either extreme of the range or zero.
   function automatic logic [15:0] rnd_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   // Vector whose component magnitudes sum to 16384, with random direction, for well-formed rays.
   task automatic unit_vec(output logic [15:0] x, output logic [15:0] y,
                           output logic [15:0] z);
      int a, b;
      a = $urandom_range(0, 16384);
      b = $urandom_range(0, 16384 - a);
      x = 16'($urandom_range(0, 1) ? -a : a);
      y = 16'($urandom_range(0, 1) ? -b : b);
      z = 16'($urandom_range(0, 1) ? -(16384 - a - b) : (16384 - a - b));
   endtask

   task automatic test_directed();
      send_ray(KIND_REFLECT, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
               16'h1000);
      send_ray(KIND_REFRACT, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
               16'h1000);
      send_ray(KIND_REFRACT, 16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
               16'h1800);
      send_ray(KIND_REFRACT, 16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
               16'h0aaa);
      send_ray(KIND_REFLECT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
               16'hffff);
      send_ray(KIND_REFLECT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
               16'h0000);
      send_ray(KIND_REFRACT, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
               16'hffff);
      send_ray(KIND_REFRACT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
               16'h0000);
      send_ray(KIND_REFRACT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
               16'h0000);
      send_ray(KIND_REFRACT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
               16'hffff);
      send_ray(KIND_REFRACT, 16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h0001, 16'hffff,
               16'h8000);
      send_ray(KIND_REFRACT, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000,
               16'h2000);
   endtask

   task automatic test_random(int count);
      logic [15:0] dx, dy, dz, nx, ny, nz, n;
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && sent < count; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               unit_vec(dx, dy, dz);
               unit_vec(nx, ny, nz);
               n = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hffff)
                                                 : $urandom_range(16'h0800, 16'h2000));
            end else begin
               dx = rnd_comp(); dy = rnd_comp(); dz = rnd_comp();
               nx = rnd_comp(); ny = rnd_comp(); nz = rnd_comp();
               n = 16'($urandom_range(0, 16'hffff));
            end
            send_ray(kind_type'($urandom_range(0, 3) != 0), dx, dy, dz, nx, ny, nz, n);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 120;
      test_random(100);
   endtask

   // Receiver: random stall pattern once stall_enable is set, plus a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else if (stall_enable) begin
         rsp_ready <= ($urandom_range(0, 7) > 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      dir_result_type exp_dir;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dirs.size() == 0) begin
            $error("unexpected result item");
            error_count++;
         end else begin
            exp_dir = pending_dirs.pop_front();
            results_seen++;
            if (exp_dir.tir) tir_seen++;
            if (rsp_out_x !== exp_dir.x) begin
               $error("out_x expected %0d actual %0d", exp_dir.x, rsp_out_x);
               error_count++;
            end
            if (rsp_out_y !== exp_dir.y) begin
               $error("out_y expected %0d actual %0d", exp_dir.y, rsp_out_y);
               error_count++;
            end
            if (rsp_out_z !== exp_dir.z) begin
               $error("out_z expected %0d actual %0d", exp_dir.z, rsp_out_z);
               error_count++;
            end
            if (rsp_total_reflection !== exp_dir.tir) begin
               $error("total_reflection expected %0d actual %0d", exp_dir.tir,
                      rsp_total_reflection);
               error_count++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      stall_enable = 1'b1;
      test_random(400);
      drain_and_set_eps(15'd0);
      test_directed();
      test_random(350);
      drain_and_set_eps(15'd16384);
      test_random(300);
      drain_and_set_eps(15'h7fff);
      test_random(250);
      drain_and_set_eps(15'd8192);
      test_backpressure();
      test_random(300);
      drain_and_set_eps(15'd1);
      test_random(200);
      idle_gap(1);
      while (pending_dirs.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      $display("Sent %0d items, checked %0d results, %0d with total reflection.",
               items_sent, results_seen, tir_seen);
      $display("Thresholds 0, 1, 8192, 16384 and 32767 with receiver stalls were run.");
      if (error_count == 0 && pending_dirs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
